### rtl/draw_sequence_digest_core_assert.svh
// Assertion macros used by the draw sequence digest controller.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef DRAW_SEQUENCE_DIGEST_CORE_ASSERT_SVH
`define DRAW_SEQUENCE_DIGEST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("draw sequence digest: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("draw sequence digest: assertion failed");

`endif

### rtl/dsd_pkg.sv
// Package for the draw sequence digest core: constants, codes and the
// command and status types that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package dsd_pkg;

  localparam logic [63:0] GoldenAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MulOne    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MulTwo    = 64'h94d049bb133111eb;
  localparam logic [63:0] SeedA     = 64'h243f6a8885a308d3;
  localparam logic [63:0] SeedB     = 64'h13198a2e03707344;
  localparam logic [63:0] LaneBMask = 64'ha4093822299f31d0;

  localparam int          WordCount = 10;
  localparam logic [3:0]  LastWord  = 4'd9;
  localparam logic [31:0] CountMax  = 32'hffff_ffff;

  // Configuration register indexes.
  localparam int          CfgIndexWidth = 2;
  localparam logic [1:0]  CfgPreserve   = 2'd0;
  localparam logic [1:0]  CfgWriteValid = 2'd1;
  localparam logic [1:0]  CfgInvalidate = 2'd2;

  localparam logic [31:0] ResetPreserve   = 32'd0;
  localparam logic [31:0] ResetWriteValid = 32'd1;
  localparam logic [31:0] ResetInvalidate = 32'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MIX,
    ST_DONE
  } ctrl_state_t;

  // One combine round: pre-mix add, then two multiplies of three partial products each.
  typedef enum logic [2:0] {
    PH_PRE,
    PH_M1A,
    PH_M1B,
    PH_M1C,
    PH_M2A,
    PH_M2B,
    PH_M2C
  } mix_phase_t;

  typedef struct packed {
    logic       clear;
    logic       seed;
    logic       step;
    mix_phase_t phase;
  } mix_cmd_t;

  typedef struct packed {
    logic       capture;
    logic       evaluate;
    logic       clear_seq;
    logic       seed;
    logic       step;
    mix_phase_t phase;
    logic       commit;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic append_ok;
    logic count_zero;
  } dp_status_t;

endpackage

### rtl/dsd_mixer.sv
// One digest lane with its shared combine unit: a 32x32 multiplier, an adder and shifts,
// sequenced one phase per cycle by the controller. Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_mixer (
  input  logic            clk,
  input  logic            rst_n,
  input  dsd_pkg::mix_cmd_t cmd,
  input  logic [63:0]     seed_value,
  input  logic [63:0]     word,
  output logic [63:0]     lane
);

  logic [63:0] lane_r, lane_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] mul_s;
  logic [31:0] mul_c;
  logic [63:0] mul_const;
  logic [63:0] prod;
  logic [63:0] pre_sum;
  logic [63:0] pre_x;
  logic [63:0] fin_sum;

  // Multiplier operands: low*low, low*high, high*low; high*high drops out modulo 2^64.
  always_comb begin
    if (cmd.phase == dsd_pkg::PH_M1A || cmd.phase == dsd_pkg::PH_M1B ||
        cmd.phase == dsd_pkg::PH_M1C) begin
      mul_const = dsd_pkg::MulOne;
    end else begin
      mul_const = dsd_pkg::MulTwo;
    end
    if (cmd.phase == dsd_pkg::PH_M1C || cmd.phase == dsd_pkg::PH_M2C) begin
      mul_s = lane_r[63:32];
    end else begin
      mul_s = lane_r[31:0];
    end
    if (cmd.phase == dsd_pkg::PH_M1B || cmd.phase == dsd_pkg::PH_M2B) begin
      mul_c = mul_const[63:32];
    end else begin
      mul_c = mul_const[31:0];
    end
  end

  assign prod    = 64'(mul_s) * 64'(mul_c);
  assign pre_sum = word + dsd_pkg::GoldenAdd + (lane_r << 6) + (lane_r >> 2);
  assign pre_x   = lane_r ^ pre_sum;
  assign fin_sum = acc_r + {prod[31:0], 32'd0};

  always_comb begin
    lane_nxt = lane_r;
    acc_nxt  = acc_r;
    if (cmd.clear) begin
      lane_nxt = 64'd0;
    end else if (cmd.seed) begin
      lane_nxt = seed_value;
    end else if (cmd.step) begin
      case (cmd.phase)
        dsd_pkg::PH_PRE: lane_nxt = pre_x ^ (pre_x >> 30);
        dsd_pkg::PH_M1A: acc_nxt  = prod;
        dsd_pkg::PH_M1B: acc_nxt  = fin_sum;
        dsd_pkg::PH_M1C: lane_nxt = fin_sum ^ (fin_sum >> 27);
        dsd_pkg::PH_M2A: acc_nxt  = prod;
        dsd_pkg::PH_M2B: acc_nxt  = fin_sum;
        dsd_pkg::PH_M2C: lane_nxt = fin_sum ^ (fin_sum >> 31);
        default:         acc_nxt  = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= 64'd0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign lane = lane_r;

endmodule

### rtl/dsd_datapath.sv
// Datapath of the draw sequence digest: configuration registers, record capture, validation,
// record count, two lane mixers and the result register. Depends on dsd_pkg and dsd_mixer.
`timescale 1ns / 1ps

module dsd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dsd_pkg::dp_cmd_t                  cmd,
  output dsd_pkg::dp_status_t               status,
  input  logic                              cfg_we,
  input  logic [dsd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_mode,
  input  logic [31:0]                       in_entity_slot,
  input  logic [31:0]                       in_pipe_slot,
  input  logic [31:0]                       in_outcome_code,
  input  logic                              in_receipt_present,
  input  logic [31:0]                       in_receipt_slot,
  input  logic [31:0]                       in_table_gen,
  input  logic [31:0]                       in_entry_gen,
  input  logic [31:0]                       in_owner_epoch,
  input  logic [31:0]                       in_recipe_gen,
  input  logic [31:0]                       in_alloc_gen,
  input  logic [31:0]                       in_catalog_ident,
  output logic                              out_accepted,
  output logic [31:0]                       out_record_count,
  output logic [63:0]                       out_digest_low,
  output logic [63:0]                       out_digest_high
);

  logic [31:0] code_preserve_r;
  logic [31:0] code_write_valid_r;
  logic [31:0] code_invalidate_r;

  logic [31:0] count_r, count_nxt;

  // Word shift lines: lane A walks words 0..9, lane B walks them 9..0.
  logic [31:0] words_a_r [dsd_pkg::WordCount];
  logic [31:0] words_b_r [dsd_pkg::WordCount];
  logic [31:0] rx_words  [dsd_pkg::WordCount];
  logic        mode_r;
  logic        rp_r;
  logic [31:0] rslot_r;
  logic        ok_r;

  logic        match_preserve;
  logic        match_receipt;
  logic        receipt_ok;
  logic        shift_words;

  logic [63:0] lane_a;
  logic [63:0] lane_b;
  dsd_pkg::mix_cmd_t mix_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_preserve_r    <= dsd_pkg::ResetPreserve;
      code_write_valid_r <= dsd_pkg::ResetWriteValid;
      code_invalidate_r  <= dsd_pkg::ResetInvalidate;
    end else if (cfg_we) begin
      case (cfg_index)
        dsd_pkg::CfgPreserve:   code_preserve_r    <= cfg_data;
        dsd_pkg::CfgWriteValid: code_write_valid_r <= cfg_data;
        dsd_pkg::CfgInvalidate: code_invalidate_r  <= cfg_data;
        default:                code_preserve_r    <= code_preserve_r;
      endcase
    end
  end

  // Receipt words enter the digest as zero when no receipt comes with the record.
  always_comb begin
    rx_words[0] = in_entity_slot;
    rx_words[1] = in_pipe_slot;
    rx_words[2] = in_outcome_code;
    rx_words[3] = in_receipt_present ? in_table_gen     : 32'd0;
    rx_words[4] = in_receipt_present ? in_entry_gen     : 32'd0;
    rx_words[5] = in_receipt_present ? in_owner_epoch   : 32'd0;
    rx_words[6] = in_receipt_present ? in_recipe_gen    : 32'd0;
    rx_words[7] = in_receipt_present ? in_alloc_gen     : 32'd0;
    rx_words[8] = in_receipt_present ? in_catalog_ident : 32'd0;
    rx_words[9] = count_r + 32'd1;
  end

  assign shift_words = cmd.step && (cmd.phase == dsd_pkg::PH_M2C);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      rp_r    <= in_receipt_present;
      rslot_r <= in_receipt_slot;
      for (int k = 0; k < dsd_pkg::WordCount; k++) begin
        words_a_r[k] <= rx_words[k];
        words_b_r[k] <= rx_words[dsd_pkg::WordCount-1-k];
      end
    end else if (shift_words) begin
      for (int k = 0; k < dsd_pkg::WordCount - 1; k++) begin
        words_a_r[k] <= words_a_r[k+1];
        words_b_r[k] <= words_b_r[k+1];
      end
    end
  end

  // The preserve code is checked first, so it wins when codes overlap.
  assign match_preserve = (words_a_r[2] == code_preserve_r);
  assign match_receipt  = (words_a_r[2] == code_write_valid_r) ||
                          (words_a_r[2] == code_invalidate_r);
  assign receipt_ok     = rp_r && (rslot_r == words_a_r[1]) &&
                          (words_a_r[3] != 32'd0) && (words_a_r[4] != 32'd0) &&
                          (words_a_r[5] != 32'd0) && (words_a_r[6] != 32'd0) &&
                          (words_a_r[7] != 32'd0) && (words_a_r[8] != 32'd0);

  always_comb begin
    status.is_clear   = mode_r;
    status.count_zero = (count_r == 32'd0);
    if (count_r == dsd_pkg::CountMax) begin
      status.append_ok = 1'b0;
    end else if (match_preserve) begin
      status.append_ok = !rp_r;
    end else if (match_receipt) begin
      status.append_ok = receipt_ok;
    end else begin
      status.append_ok = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_seq) begin
      count_nxt = 32'd0;
    end else if (cmd.commit) begin
      count_nxt = count_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 32'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      ok_r <= mode_r || status.append_ok;
    end
  end

  assign mix_cmd.clear = cmd.clear_seq;
  assign mix_cmd.seed  = cmd.seed;
  assign mix_cmd.step  = cmd.step;
  assign mix_cmd.phase = cmd.phase;

  dsd_mixer u_mix_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mix_cmd),
    .seed_value (dsd_pkg::SeedA),
    .word       ({32'd0, words_a_r[0]}),
    .lane       (lane_a)
  );

  dsd_mixer u_mix_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mix_cmd),
    .seed_value (dsd_pkg::SeedB),
    .word       ({32'd0, words_b_r[0]} ^ dsd_pkg::LaneBMask),
    .lane       (lane_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted     <= ok_r;
      out_record_count <= count_r;
      out_digest_low   <= lane_a;
      out_digest_high  <= lane_b;
    end
  end

endmodule

### rtl/dsd_ctrl.sv
// Controller of the draw sequence digest: request handshakes and the sequencing of the
// ten combine rounds of seven phases each. Depends on dsd_pkg and the assertion header.
`timescale 1ns / 1ps

`include "draw_sequence_digest_core_assert.svh"

module dsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dsd_pkg::dp_status_t status,
  output dsd_pkg::dp_cmd_t    cmd
);

  dsd_pkg::ctrl_state_t state_r, state_nxt;
  dsd_pkg::mix_phase_t  phase_r, phase_nxt;
  logic [3:0]           word_r, word_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Next state, round counters and result-valid flag.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      dsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dsd_pkg::ST_EVAL;
        end
      end
      dsd_pkg::ST_EVAL: begin
        phase_nxt = dsd_pkg::PH_PRE;
        word_nxt  = 4'd0;
        if (!status.is_clear && status.append_ok) begin
          state_nxt = dsd_pkg::ST_MIX;
        end else begin
          state_nxt = dsd_pkg::ST_DONE;
        end
      end
      dsd_pkg::ST_MIX: begin
        case (phase_r)
          dsd_pkg::PH_PRE: phase_nxt = dsd_pkg::PH_M1A;
          dsd_pkg::PH_M1A: phase_nxt = dsd_pkg::PH_M1B;
          dsd_pkg::PH_M1B: phase_nxt = dsd_pkg::PH_M1C;
          dsd_pkg::PH_M1C: phase_nxt = dsd_pkg::PH_M2A;
          dsd_pkg::PH_M2A: phase_nxt = dsd_pkg::PH_M2B;
          dsd_pkg::PH_M2B: phase_nxt = dsd_pkg::PH_M2C;
          default: begin
            phase_nxt = dsd_pkg::PH_PRE;
            word_nxt  = word_r + 4'd1;
            if (word_r == dsd_pkg::LastWord) begin
              state_nxt = dsd_pkg::ST_DONE;
            end
          end
        endcase
      end
      dsd_pkg::ST_DONE: begin
        if (cmd.load_out) begin
          state_nxt = dsd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    cmd.phase = phase_r;
    in_stall  = 1'b1;
    unique case (state_r)
      dsd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      dsd_pkg::ST_EVAL: begin
        cmd.evaluate  = 1'b1;
        cmd.clear_seq = status.is_clear;
        cmd.seed      = !status.is_clear && status.append_ok && status.count_zero;
      end
      dsd_pkg::ST_MIX: begin
        cmd.step   = 1'b1;
        cmd.commit = (phase_r == dsd_pkg::PH_M2C) && (word_r == dsd_pkg::LastWord);
      end
      dsd_pkg::ST_DONE: begin
        cmd.load_out = !out_valid_r || !out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsd_pkg::ST_IDLE;
      phase_r     <= dsd_pkg::PH_PRE;
      word_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DSD_ASSERT_SAME(a_mix_word_range, clk, rst_n, state_r == dsd_pkg::ST_MIX, word_r <= dsd_pkg::LastWord)
  `DSD_ASSERT_NEXT(a_last_round_done, clk, rst_n, (state_r == dsd_pkg::ST_MIX) && (phase_r == dsd_pkg::PH_M2C) && (word_r == dsd_pkg::LastWord), state_r == dsd_pkg::ST_DONE)
  `DSD_ASSERT_NEXT(a_reject_skips_mix, clk, rst_n, (state_r == dsd_pkg::ST_EVAL) && !status.append_ok, state_r == dsd_pkg::ST_DONE)
  `DSD_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out, out_valid_r)

endmodule

### rtl/draw_sequence_digest_core.sv
// Draw sequence digest core. The record channel (in_*) carries one append or clear
// request; the result channel (out_*) returns one result per request: accepted flag, record
// count and both digest lanes. The cfg_* port writes the three outcome code registers.
// Both data channels use valid/stall; cfg_ready is always high. Write configuration only
// while the block is idle.
// An append that passes validation goes through capture, evaluate, mixing and result load;
// the mixing runs ten combine rounds of seven phases each, one phase at a time, as the
// one 32x32 multiplier is shared within each lane's mixer. A clear or rejected append skips
// the mixing. The result is valid in the cycle after the load.
// One request is in flight at a time; a result waiting in the output register does not stop
// the next request from being accepted, but the next result waits until the first is taken.
// Reset clears the count, both lanes and the handshakes and restores the default codes
// (preserve 0, write valid 1, invalidate 2). Depends on dsd_pkg, dsd_ctrl and dsd_datapath.
`timescale 1ns / 1ps

module draw_sequence_digest_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [31:0]                       in_entity_slot,
  input  logic [31:0]                       in_pipe_slot,
  input  logic [31:0]                       in_outcome_code,
  input  logic                              in_receipt_present,
  input  logic [31:0]                       in_receipt_slot,
  input  logic [31:0]                       in_table_gen,
  input  logic [31:0]                       in_entry_gen,
  input  logic [31:0]                       in_owner_epoch,
  input  logic [31:0]                       in_recipe_gen,
  input  logic [31:0]                       in_alloc_gen,
  input  logic [31:0]                       in_catalog_ident,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [31:0]                       out_record_count,
  output logic [63:0]                       out_digest_low,
  output logic [63:0]                       out_digest_high,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dsd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);

  dsd_pkg::dp_cmd_t    cmd;
  dsd_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  dsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dsd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_mode),
    .in_entity_slot     (in_entity_slot),
    .in_pipe_slot       (in_pipe_slot),
    .in_outcome_code    (in_outcome_code),
    .in_receipt_present (in_receipt_present),
    .in_receipt_slot    (in_receipt_slot),
    .in_table_gen       (in_table_gen),
    .in_entry_gen       (in_entry_gen),
    .in_owner_epoch     (in_owner_epoch),
    .in_recipe_gen      (in_recipe_gen),
    .in_alloc_gen       (in_alloc_gen),
    .in_catalog_ident   (in_catalog_ident),
    .out_accepted       (out_accepted),
    .out_record_count   (out_record_count),
    .out_digest_low     (out_digest_low),
    .out_digest_high    (out_digest_high)
  );

endmodule

### sim/draw_sequence_digest_core_test.sv
// Self-checking testbench for draw_sequence_digest_core: a table of directed requests, then
// random phases under several outcome code settings, with bursty input and a stalling sink.
// Depends on dsd_pkg for the configuration register indexes and on the core itself.
`timescale 1ns / 1ps

module draw_sequence_digest_core_test;

  localparam logic [63:0] GoldenStep   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FirstMul     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SecondMul    = 64'h94d049bb133111eb;
  localparam logic [63:0] SeedLow      = 64'h243f6a8885a308d3;
  localparam logic [63:0] SeedHigh     = 64'h13198a2e03707344;
  localparam logic [63:0] HighLaneMask = 64'ha4093822299f31d0;
  localparam logic [31:0] CountFull    = 32'hffff_ffff;
  localparam int          WordTotal    = 10;
  localparam int          DirectedRows = 20;
  localparam int          CodePhases   = 5;
  localparam int          PhaseItems   = 376;
  localparam logic        ModeAppend   = 1'b0;
  localparam logic        ModeClear    = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] entity_slot;
    logic [31:0] pipe_slot;
    logic [31:0] outcome_code;
    logic        receipt_present;
    logic [31:0] receipt_slot;
    logic [31:0] table_gen;
    logic [31:0] entry_gen;
    logic [31:0] owner_epoch;
    logic [31:0] recipe_gen;
    logic [31:0] alloc_gen;
    logic [31:0] catalog_ident;
  } draw_req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] record_count;
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } digest_result_t;

  typedef struct packed {
    draw_req_t      req;
    logic           pinned;
    digest_result_t want;
  } directed_row_t;

  localparam digest_result_t EmptyReject   = '{1'b0, 32'd0, 64'd0, 64'd0};
  localparam digest_result_t ClearedResult = '{1'b1, 32'd0, 64'd0, 64'd0};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic out_accepted;
  logic [31:0] out_record_count;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;
  logic cfg_valid;
  logic cfg_ready;
  logic [dsd_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [31:0] cfg_data;

  // The request on offer, and a typed-in result that replaces the computed one when pinned.
  draw_req_t      offered;
  logic           offer_pinned;
  digest_result_t offer_want;

  // Running copy of the sequence state and the outcome code registers.
  logic [31:0] seq_count;
  logic [63:0] lane_low;
  logic [63:0] lane_high;
  logic [31:0] preserve_code;
  logic [31:0] write_valid_code;
  logic [31:0] invalidate_code;

  digest_result_t pending_digests[$];
  int failure_count;
  int requests_sent;
  int results_seen;
  int burst_left;

  directed_row_t directed_table [DirectedRows];

  draw_sequence_digest_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (offered.mode),
    .in_entity_slot     (offered.entity_slot),
    .in_pipe_slot       (offered.pipe_slot),
    .in_outcome_code    (offered.outcome_code),
    .in_receipt_present (offered.receipt_present),
    .in_receipt_slot    (offered.receipt_slot),
    .in_table_gen       (offered.table_gen),
    .in_entry_gen       (offered.entry_gen),
    .in_owner_epoch     (offered.owner_epoch),
    .in_recipe_gen      (offered.recipe_gen),
    .in_alloc_gen       (offered.alloc_gen),
    .in_catalog_ident   (offered.catalog_ident),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_record_count   (out_record_count),
    .out_digest_low     (out_digest_low),
    .out_digest_high    (out_digest_high),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] splitmix_combine(input logic [63:0] s, input logic [63:0] v);
    s = s ^ (v + GoldenStep + (s << 6) + (s >> 2));
    s = s ^ (s >> 30);
    s = s * FirstMul;
    s = s ^ (s >> 27);
    s = s * SecondMul;
    return s ^ (s >> 31);
  endfunction

  function automatic digest_result_t predict_digest(input draw_req_t r);
    logic [63:0] words [WordTotal];
    logic [63:0] a;
    logic [63:0] b;
    logic        ok;
    int          k;
    ok = 1'b0;
    if (r.mode == ModeClear) begin
      seq_count = '0;
      lane_low  = '0;
      lane_high = '0;
      ok = 1'b1;
    end else if (seq_count != CountFull) begin
      // Preserve is compared first, so it wins when the code registers overlap.
      if (r.outcome_code == preserve_code) begin
        ok = !r.receipt_present;
      end else if (r.outcome_code == write_valid_code || r.outcome_code == invalidate_code) begin
        ok = r.receipt_present && r.receipt_slot == r.pipe_slot && r.table_gen != 0
             && r.entry_gen != 0 && r.owner_epoch != 0 && r.recipe_gen != 0
             && r.alloc_gen != 0 && r.catalog_ident != 0;
      end
      if (ok) begin
        words[0] = {32'd0, r.entity_slot};
        words[1] = {32'd0, r.pipe_slot};
        words[2] = {32'd0, r.outcome_code};
        words[3] = r.receipt_present ? {32'd0, r.table_gen} : 64'd0;
        words[4] = r.receipt_present ? {32'd0, r.entry_gen} : 64'd0;
        words[5] = r.receipt_present ? {32'd0, r.owner_epoch} : 64'd0;
        words[6] = r.receipt_present ? {32'd0, r.recipe_gen} : 64'd0;
        words[7] = r.receipt_present ? {32'd0, r.alloc_gen} : 64'd0;
        words[8] = r.receipt_present ? {32'd0, r.catalog_ident} : 64'd0;
        words[9] = {32'd0, seq_count} + 64'd1;
        a = (seq_count == 0) ? SeedLow : lane_low;
        b = (seq_count == 0) ? SeedHigh : lane_high;
        for (k = 0; k < WordTotal; k++) begin
          a = splitmix_combine(a, words[k]);
          b = splitmix_combine(b, words[WordTotal - 1 - k] ^ HighLaneMask);
        end
        lane_low  = a;
        lane_high = b;
        seq_count = seq_count + 32'd1;
      end
    end
    return '{ok, seq_count, lane_low, lane_high};
  endfunction

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      failure_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Results are checked before the request taken at the same edge is queued.
  always @(posedge clk) begin
    digest_result_t want;
    digest_result_t computed;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_digests.size() == 0) begin
          failure_count++;
          $display("%0t: result with none expected, expected nothing, actual %h %h %h %h",
                   $time, out_accepted, out_record_count, out_digest_low, out_digest_high);
        end else begin
          want = pending_digests.pop_front();
          compare_field("accepted", {63'd0, want.accepted}, {63'd0, out_accepted});
          compare_field("record_count", {32'd0, want.record_count}, {32'd0, out_record_count});
          compare_field("digest_low", want.digest_low, out_digest_low);
          compare_field("digest_high", want.digest_high, out_digest_high);
        end
      end
      if (in_valid && !in_stall) begin
        computed = predict_digest(offered);
        pending_digests.push_back(offer_pinned ? offer_want : computed);
      end
    end
  end

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] w;
    w = any_word();
    if (w == 0) w = 32'd1 << $urandom_range(0, 31);
    return w;
  endfunction

  function automatic draw_req_t make_request(input logic mode, input logic [31:0] entity,
                                             input logic [31:0] pipe, input logic [31:0] outcome,
                                             input logic rp, input logic [31:0] rslot,
                                             input logic [31:0] tg, input logic [31:0] eg,
                                             input logic [31:0] oe, input logic [31:0] rg,
                                             input logic [31:0] ag, input logic [31:0] ci);
    return '{mode, entity, pipe, outcome, rp, rslot, tg, eg, oe, rg, ag, ci};
  endfunction

  // Mostly well-formed appends against the current codes; the rest clears and broken records.
  function automatic draw_req_t random_request();
    draw_req_t r;
    int pick;
    r = make_request(ModeAppend, any_word(), any_word(), 32'd0, 1'b1, 32'd0, nonzero_word(),
                     nonzero_word(), nonzero_word(), nonzero_word(), nonzero_word(),
                     nonzero_word());
    r.receipt_slot = r.pipe_slot;
    r.outcome_code = $urandom_range(0, 1) ? write_valid_code : invalidate_code;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.mode = ModeClear;
      r.outcome_code = any_word();
      r.receipt_present = 1'($urandom_range(0, 1));
    end else if (pick < 30) begin
      r.outcome_code = preserve_code;
      r.receipt_present = 1'b0;
      r.receipt_slot = any_word();
      r.table_gen = any_word();
      r.catalog_ident = any_word();
    end else if (pick >= 78) begin
      case ($urandom_range(0, 4))
        0: begin
          r.outcome_code = any_word();
          r.receipt_present = 1'($urandom_range(0, 1));
        end
        1: r.receipt_present = 1'b0;
        2: r.receipt_slot = r.pipe_slot ^ (32'd1 << $urandom_range(0, 31));
        3: begin
          case ($urandom_range(0, 5))
            0: r.table_gen = '0;
            1: r.entry_gen = '0;
            2: r.owner_epoch = '0;
            3: r.recipe_gen = '0;
            4: r.alloc_gen = '0;
            default: r.catalog_ident = '0;
          endcase
        end
        default: r.outcome_code = preserve_code;
      endcase
    end
    return r;
  endfunction

  task automatic offer_request(input draw_req_t r, input logic pin, input digest_result_t want);
    in_valid     <= 1'b1;
    offered      <= r;
    offer_pinned <= pin;
    offer_want   <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
    requests_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(9, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_codes(input logic [31:0] preserve, input logic [31:0] write_valid,
                               input logic [31:0] invalidate);
    logic [dsd_pkg::CfgIndexWidth-1:0] reg_index [3];
    logic [31:0] reg_value [3];
    int k;
    reg_index[0] = dsd_pkg::CfgPreserve;
    reg_index[1] = dsd_pkg::CfgWriteValid;
    reg_index[2] = dsd_pkg::CfgInvalidate;
    reg_value[0] = preserve;
    reg_value[1] = write_valid;
    reg_value[2] = invalidate;
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[k];
      cfg_data  <= reg_value[k];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      case (reg_index[k])
        dsd_pkg::CfgPreserve:   preserve_code    = reg_value[k];
        dsd_pkg::CfgWriteValid: write_valid_code = reg_value[k];
        default:                invalidate_code  = reg_value[k];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Sink: stall style changes every stretch; two long hold-offs back the block up.
  initial begin : result_sink
    int style;
    int stretch;
    int hold;
    int holdoffs_done;
    out_stall = 1'b0;
    style = 0;
    stretch = 0;
    hold = 0;
    holdoffs_done = 0;
    forever begin
      @(posedge clk);
      if (hold == 0 && holdoffs_done < 2 &&
          results_seen >= (holdoffs_done == 0 ? 150 : 1100)) begin
        hold = 700;
        holdoffs_done++;
      end
      if (stretch == 0) begin
        style = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
      end
      stretch--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    int row;
    int phase;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    offered = '0;
    offer_pinned = 1'b0;
    offer_want = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    seq_count = '0;
    lane_low = '0;
    lane_high = '0;
    preserve_code = 32'd0;
    write_valid_code = 32'd1;
    invalidate_code = 32'd2;
    failure_count = 0;
    requests_sent = 0;
    results_seen = 0;
    burst_left = $urandom_range(1, 40);

    // Rejections from the empty state read back all zeros; a clear always reads back empty.
    directed_table[0]  = '{make_request(ModeAppend, 1, 2, 0, 1, 2, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[1]  = '{make_request(ModeAppend, 1, 2, 3, 1, 2, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[2]  = '{make_request(ModeAppend, 1, 2, 1, 0, 2, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[3]  = '{make_request(ModeAppend, 1, 2, 1, 1, 3, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[4]  = '{make_request(ModeAppend, 1, 2, 1, 1, 2, 0, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[5]  = '{make_request(ModeAppend, 1, 2, 1, 1, 2, 1, 0, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[6]  = '{make_request(ModeAppend, 1, 2, 2, 1, 2, 1, 1, 0, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[7]  = '{make_request(ModeAppend, 1, 2, 2, 1, 2, 1, 1, 1, 0, 1, 1),
                           1'b1, EmptyReject};
    directed_table[8]  = '{make_request(ModeAppend, 1, 2, 1, 1, 2, 1, 1, 1, 1, 0, 1),
                           1'b1, EmptyReject};
    directed_table[9]  = '{make_request(ModeAppend, 1, 2, 2, 1, 2, 1, 1, 1, 1, 1, 0),
                           1'b1, EmptyReject};
    directed_table[10] = '{make_request(ModeAppend, 1, 2, 2, 0, 2, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};
    directed_table[11] = '{make_request(ModeAppend, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff),
                           1'b0, EmptyReject};
    directed_table[12] = '{make_request(ModeAppend, 32'hffff_ffff, 32'hffff_ffff, 1, 1,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff),
                           1'b0, EmptyReject};
    directed_table[13] = '{make_request(ModeAppend, 0, 0, 2, 1, 0, 1, 1, 1, 1, 1, 1),
                           1'b0, EmptyReject};
    directed_table[14] = '{make_request(ModeAppend, 5, 6, 32'hffff_ffff, 1, 6, 1, 1, 1, 1, 1, 1),
                           1'b0, EmptyReject};
    directed_table[15] = '{make_request(ModeClear, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b1, ClearedResult};
    directed_table[16] = '{make_request(ModeClear, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b1, ClearedResult};
    directed_table[17] = '{make_request(ModeAppend, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b0, EmptyReject};
    directed_table[18] = '{make_request(ModeClear, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff),
                           1'b1, ClearedResult};
    directed_table[19] = '{make_request(ModeAppend, 9, 9, 1, 1, 8, 1, 1, 1, 1, 1, 1),
                           1'b1, EmptyReject};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DirectedRows; row++) begin
      offer_request(directed_table[row].req, directed_table[row].pinned,
                    directed_table[row].want);
    end
    settle();

    for (phase = 0; phase < CodePhases; phase++) begin
      case (phase)
        0: program_codes(32'hffff_ffff, 32'h0, 32'h8000_0000);
        1: program_codes(32'd7, 32'd7, 32'd7);
        2: program_codes(32'h5, 32'hdead_beef, 32'hdead_beef);
        3: program_codes($urandom(), $urandom(), $urandom());
        default: program_codes(32'h0, 32'hffff_ffff, 32'h1);
      endcase
      for (n = 0; n < PhaseItems; n++) offer_request(random_request(), 1'b0, EmptyReject);
      settle();
    end

    repeat (100) @(posedge clk);
    if (pending_digests.size() != 0) begin
      failure_count++;
      $display("%0t: results still outstanding, expected 0, actual %0d", $time,
               pending_digests.size());
    end
    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### draw_sequence_digest_core.f
+incdir+rtl
rtl/dsd_pkg.sv
rtl/dsd_mixer.sv
rtl/dsd_datapath.sv
rtl/dsd_ctrl.sv
rtl/draw_sequence_digest_core.sv
sim/draw_sequence_digest_core_test.sv
